/* rtl/core/rrs_pkg.sv */
// ----------------------------------------------------------------------------
// RTP receiver statistics package
// Shared item types, command codes, register indexes and divider handshake.
// ----------------------------------------------------------------------------
package rrs_pkg;

   // Command codes carried in the item's cmd field.
   localparam logic [2:0] CMD_PACKET = 3'd0;
   localparam logic [2:0] CMD_SR     = 3'd1;
   localparam logic [2:0] CMD_SDES   = 3'd2;
   localparam logic [2:0] CMD_REPORT = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INACTIVE_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELETE_TIMEOUT = 1'b1;

   // Register reset values.
   localparam logic [7:0]  INACTIVE_LIMIT_RST = 8'd5;
   localparam logic [47:0] DELETE_TIMEOUT_RST = 48'd117964800;

   // Sequence number wrap window.
   localparam logic [15:0] SEQ_WIN_HI = 16'hFFEF;
   localparam logic [15:0] SEQ_WIN_LO = 16'h0010;

   // Divider sizing.
   localparam int DIV_W       = 64;
   localparam int DIV_STEPS_W = 7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] seq_number;
      logic [31:0] rtp_timestamp;
      logic [63:0] ntp_timestamp;
      logic [47:0] event_time;
   } req_type;

   typedef struct packed {
      logic               report_valid;
      logic [7:0]         fraction_lost;
      logic signed [31:0] cumulative_lost;
      logic [31:0]        extended_highest_seq;
      logic [31:0]        jitter_out;
      logic [31:0]        last_sr;
      logic [31:0]        delay_since_sr;
      logic               is_active;
      logic               is_validated;
      logic               to_delete;
   } rsp_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_W-1:0]       rem_init;
      logic [DIV_W-1:0]       num;
      logic [DIV_W-1:0]       divisor;
      logic [DIV_STEPS_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

/* rtl/core/rrs_div.sv */
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle; the remainder may start nonzero so a
// short division needs only as many steps as quotient bits wanted.
// ----------------------------------------------------------------------------
module rrs_div (
   input  logic                clock,
   input  logic                reset,
   input  rrs_pkg::div_req_type div_req,
   output rrs_pkg::div_rsp_type div_rsp
);

   logic [rrs_pkg::DIV_W-1:0]       rem_ff, rem_in;
   logic [rrs_pkg::DIV_W-1:0]       num_ff, num_in;
   logic [rrs_pkg::DIV_W-1:0]       quot_ff, quot_in;
   logic [rrs_pkg::DIV_W-1:0]       divisor_ff, divisor_in;
   logic [rrs_pkg::DIV_STEPS_W-1:0] cnt_ff, cnt_in;
   logic [rrs_pkg::DIV_STEPS_W-1:0] steps_ff, steps_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [rrs_pkg::DIV_W:0]         shifted;
   logic                            fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign shifted = {rem_ff, num_ff[rrs_pkg::DIV_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      num_in     = num_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      steps_in   = steps_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = div_req.rem_init;
         num_in     = div_req.num;
         quot_in    = '0;
         divisor_in = div_req.divisor;
         steps_in   = div_req.steps;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? shifted[rrs_pkg::DIV_W-1:0] - divisor_ff
                        : shifted[rrs_pkg::DIV_W-1:0];
         num_in  = {num_ff[rrs_pkg::DIV_W-2:0], 1'b0};
         quot_in = {quot_ff[rrs_pkg::DIV_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == steps_ff - 1'b1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      steps_ff   <= steps_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* rtl/core/rrs_front.sv */
// ----------------------------------------------------------------------------
// RTP receiver statistics front end
// Accepts items, drops unused command codes and queues the rest for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module rrs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rrs_pkg::req_type req_data,
   output logic             q_valid,
   output rrs_pkg::req_type q_item,
   input  logic             q_pop
);

   rrs_pkg::req_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;

   // Only known commands enter the queue; the rest are taken and dropped.
   assign req_stall = count_ff == 2'd2;
   assign push      = req_valid && !req_stall && (req_data.cmd <= rrs_pkg::CMD_TICK);
   assign q_valid   = count_ff != 2'd0;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

/* rtl/core/rrs_back.sv */
// ----------------------------------------------------------------------------
// RTP receiver statistics back end
// Sequencer that carries out queued items: sequence tracking, jitter with a
// shared 18x32 multiplier, clock rate and fraction lost through the divider,
// and the report output register.
// ----------------------------------------------------------------------------
module rrs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rrs_pkg::req_type q_item,
   output logic             q_pop,
   input  logic [7:0]       inactive_limit,
   input  logic [47:0]      delete_timeout,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rrs_pkg::rsp_type rsp_data
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_PKT     = 5'd1;
   localparam logic [4:0] ST_JM0     = 5'd2;
   localparam logic [4:0] ST_JM1     = 5'd3;
   localparam logic [4:0] ST_JM2     = 5'd4;
   localparam logic [4:0] ST_JSUM    = 5'd5;
   localparam logic [4:0] ST_JTERM   = 5'd6;
   localparam logic [4:0] ST_JABS    = 5'd7;
   localparam logic [4:0] ST_JCAP    = 5'd8;
   localparam logic [4:0] ST_JUPD    = 5'd9;
   localparam logic [4:0] ST_SR      = 5'd10;
   localparam logic [4:0] ST_SRDIV   = 5'd11;
   localparam logic [4:0] ST_SRWAIT  = 5'd12;
   localparam logic [4:0] ST_REQ0    = 5'd13;
   localparam logic [4:0] ST_REQ1    = 5'd14;
   localparam logic [4:0] ST_REQWAIT = 5'd15;
   localparam logic [4:0] ST_OUT     = 5'd16;

   // Source statistics.
   logic [15:0] seq_base_ff, seq_base_in;
   logic [15:0] highest_ff, highest_in;
   logic [15:0] wrap_ff, wrap_in;
   logic [31:0] prior_ext_ff, prior_ext_in;
   logic [31:0] pkts_ff, pkts_in;
   logic [31:0] pkts_prior_ff, pkts_prior_in;
   logic [35:0] jitter_ff, jitter_in;
   logic [31:0] clock_rate_ff, clock_rate_in;
   logic [31:0] sr_rtp_ff, sr_rtp_in;
   logic [63:0] sr_ntp_ff, sr_ntp_in;
   logic [31:0] last_stamp_ff, last_stamp_in;
   logic [47:0] last_arrival_ff, last_arrival_in;
   logic [47:0] sr_arrival_ff, sr_arrival_in;
   logic [7:0]  inactive_ff, inactive_in;
   logic [47:0] inact_start_ff, inact_start_in;
   logic [31:0] items_ff, items_in;
   logic        sender_seen_ff, sender_seen_in;
   logic        sr_seen_ff, sr_seen_in;
   logic [31:0] last_sr_mid_ff, last_sr_mid_in;

   // Sequencer and work registers.
   logic [4:0]         state_ff, state_in;
   rrs_pkg::req_type   cur_ff, cur_in;
   logic [47:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [31:0]        tsd_ff, tsd_in;
   logic [49:0]        plo_ff, plo_in;
   logic [49:0]        phi_ff, phi_in;
   logic [31:0]        rc_ff, rc_in;
   logic               ovf_ff, ovf_in;
   logic [40:0]        psum_ff, psum_in;
   logic [41:0]        term_ff, term_in;
   logic [43:0]        d_ff, d_in;
   logic [35:0]        ad_ff, ad_in;
   logic [30:0]        ticks_ff, ticks_in;
   logic [63:0]        nd_ff, nd_in;
   logic [33:0]        expected_ff, expected_in;
   logic [31:0]        exp_i_ff, exp_i_in;
   logic [31:0]        rec_i_ff, rec_i_in;
   logic [31:0]        lost_ff, lost_in;
   logic [7:0]         frac_ff, frac_in;
   logic [31:0]        dlsr_ff, dlsr_in;
   logic               rv_ff, rv_in;
   logic               active_ff, active_in;
   logic               validated_ff, validated_in;
   logic               delete_ff, delete_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rrs_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [17:0]        mul_a;
   logic [49:0]        mul_p;
   logic [31:0]        ext;
   logic [47:0]        dt;
   logic [67:0]        psum;
   logic [43:0]        tsd16;
   logic [43:0]        dabs;
   logic [35:0]        j_up;
   logic [35:0]        j_dn;
   logic [31:0]        ticks;
   logic [63:0]        nd;
   logic [7:0]         inact_next;
   logic [47:0]        sr_gap;
   logic [47:0]        idle_gap;
   logic signed [34:0] lost35;
   logic signed [32:0] lost_i;
   logic               rsp_free;
   rrs_pkg::div_req_type div_req;
   rrs_pkg::div_rsp_type div_rsp;

   rrs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Shared multiplier: one slice of the arrival term per cycle.
   assign mul_p = mul_a * clock_rate_ff;

   // Datapath terms used by the sequencer.
   assign ext        = {wrap_ff, highest_ff};
   assign dt         = cur_ff.event_time - last_arrival_ff;
   assign psum       = {phi_ff, 18'd0} + {18'd0, plo_ff};
   assign tsd16      = {{8{tsd_ff[31]}}, tsd_ff, 4'd0};
   assign dabs       = d_ff[43] ? 44'd0 - d_ff : d_ff;
   assign j_up       = ad_ff - jitter_ff;
   assign j_dn       = jitter_ff - ad_ff;
   assign ticks      = cur_ff.rtp_timestamp - sr_rtp_ff;
   assign nd         = cur_ff.ntp_timestamp - sr_ntp_ff;
   assign inact_next = (inactive_ff == 8'hFF) ? inactive_ff : inactive_ff + 8'd1;
   assign sr_gap     = cur_ff.event_time - sr_arrival_ff;
   assign idle_gap   = cur_ff.event_time - inact_start_ff;
   assign lost35     = $signed({expected_ff[33], expected_ff}) - $signed({3'd0, pkts_ff});
   assign lost_i     = $signed({exp_i_ff[31], exp_i_ff}) - $signed({rec_i_ff[31], rec_i_ff});
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      seq_base_in     = seq_base_ff;
      highest_in      = highest_ff;
      wrap_in         = wrap_ff;
      prior_ext_in    = prior_ext_ff;
      pkts_in         = pkts_ff;
      pkts_prior_in   = pkts_prior_ff;
      jitter_in       = jitter_ff;
      clock_rate_in   = clock_rate_ff;
      sr_rtp_in       = sr_rtp_ff;
      sr_ntp_in       = sr_ntp_ff;
      last_stamp_in   = last_stamp_ff;
      last_arrival_in = last_arrival_ff;
      sr_arrival_in   = sr_arrival_ff;
      inactive_in     = inactive_ff;
      inact_start_in  = inact_start_ff;
      items_in        = items_ff;
      sender_seen_in  = sender_seen_ff;
      sr_seen_in      = sr_seen_ff;
      last_sr_mid_in  = last_sr_mid_ff;
      state_in        = state_ff;
      cur_in          = cur_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      tsd_in          = tsd_ff;
      plo_in          = plo_ff;
      phi_in          = phi_ff;
      rc_in           = rc_ff;
      ovf_in          = ovf_ff;
      psum_in         = psum_ff;
      term_in         = term_ff;
      d_in            = d_ff;
      ad_in           = ad_ff;
      ticks_in        = ticks_ff;
      nd_in           = nd_ff;
      expected_in     = expected_ff;
      exp_i_in        = exp_i_ff;
      rec_i_in        = rec_i_ff;
      lost_in         = lost_ff;
      frac_in         = frac_ff;
      dlsr_in         = dlsr_ff;
      rv_in           = rv_ff;
      active_in       = active_ff;
      validated_in    = validated_ff;
      delete_in       = delete_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      q_pop           = 1'b0;
      mul_a           = {6'd0, mag_ff[11:0]};
      div_req         = '0;

      case (state_ff)
         // Take the next item; description chunks and ticks finish here.
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               case (q_item.cmd)
                  rrs_pkg::CMD_PACKET: begin
                     state_in = ST_PKT;
                  end
                  rrs_pkg::CMD_SR: begin
                     state_in = ST_SR;
                  end
                  rrs_pkg::CMD_SDES: begin
                     inactive_in = 8'd0;
                     items_in    = (items_ff == 32'hFFFF_FFFF) ? items_ff : items_ff + 32'd1;
                  end
                  rrs_pkg::CMD_REPORT: begin
                     state_in = ST_REQ0;
                  end
                  rrs_pkg::CMD_TICK: begin
                     inactive_in   = inact_next;
                     prior_ext_in  = ext;
                     pkts_prior_in = pkts_ff;
                     if (inact_next == inactive_limit) begin
                        inact_start_in = q_item.event_time;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Data packet: sequence tracking, then the jitter steps if a rate is known.
         ST_PKT: begin
            inactive_in     = 8'd0;
            items_in        = (items_ff == 32'hFFFF_FFFF) ? items_ff : items_ff + 32'd1;
            pkts_in         = pkts_ff + 32'd1;
            last_stamp_in   = cur_ff.rtp_timestamp;
            last_arrival_in = cur_ff.event_time;
            state_in        = ST_IDLE;
            if (!sender_seen_ff) begin
               sender_seen_in = 1'b1;
               seq_base_in    = cur_ff.seq_number;
               highest_in     = cur_ff.seq_number;
               prior_ext_in   = {16'd0, cur_ff.seq_number} - 32'd1;
            end else begin
               if (cur_ff.seq_number > highest_ff) begin
                  if (!(cur_ff.seq_number > rrs_pkg::SEQ_WIN_HI &&
                        highest_ff < rrs_pkg::SEQ_WIN_LO)) begin
                     highest_in = cur_ff.seq_number;
                  end
               end else if (cur_ff.seq_number < rrs_pkg::SEQ_WIN_LO &&
                            highest_ff > rrs_pkg::SEQ_WIN_HI) begin
                  wrap_in    = wrap_ff + 16'd1;
                  highest_in = cur_ff.seq_number;
               end
               if (clock_rate_ff != 32'd0) begin
                  neg_in   = dt[47];
                  mag_in   = dt[47] ? 48'd0 - dt : dt;
                  tsd_in   = cur_ff.rtp_timestamp - last_stamp_ff;
                  state_in = ST_JM0;
               end
            end
         end

         // Arrival term: low and high halves of the whole units, then the fraction.
         ST_JM0: begin
            mul_a    = mag_ff[29:12];
            plo_in   = mul_p;
            state_in = ST_JM1;
         end
         ST_JM1: begin
            mul_a    = mag_ff[47:30];
            phi_in   = mul_p;
            state_in = ST_JM2;
         end
         ST_JM2: begin
            mul_a    = {6'd0, mag_ff[11:0]};
            rc_in    = mul_p[43:12];
            state_in = ST_JSUM;
         end
         ST_JSUM: begin
            ovf_in   = psum > (68'd1 << 40);
            psum_in  = psum[40:0];
            state_in = ST_JTERM;
         end
         ST_JTERM: begin
            term_in  = ovf_ff ? (42'd1 << 40) : {1'b0, psum_ff} + {10'd0, rc_ff};
            state_in = ST_JABS;
         end

         // Transit difference in 1/16 units, then its capped magnitude.
         ST_JABS: begin
            d_in     = neg_ff ? tsd16 + {2'd0, term_ff} : tsd16 - {2'd0, term_ff};
            state_in = ST_JCAP;
         end
         ST_JCAP: begin
            ad_in    = (dabs > {8'd0, 36'hF_FFFF_FFFF}) ? 36'hF_FFFF_FFFF : dabs[35:0];
            state_in = ST_JUPD;
         end

         // Move the jitter a sixteenth of the way toward the new difference.
         ST_JUPD: begin
            jitter_in = (ad_ff >= jitter_ff) ? jitter_ff + {4'd0, j_up[35:4]}
                                             : jitter_ff - {4'd0, j_dn[35:4]};
            state_in  = ST_IDLE;
         end

         // Sender report: keep the stamps, learn the clock rate from a later one.
         ST_SR: begin
            inactive_in    = 8'd0;
            items_in       = (items_ff == 32'hFFFF_FFFF) ? items_ff : items_ff + 32'd1;
            sr_arrival_in  = cur_ff.event_time;
            last_sr_mid_in = cur_ff.ntp_timestamp[47:16];
            state_in       = ST_IDLE;
            if (!sr_seen_ff) begin
               sr_seen_in = 1'b1;
               sr_rtp_in  = cur_ff.rtp_timestamp;
               sr_ntp_in  = cur_ff.ntp_timestamp;
            end else if (clock_rate_ff == 32'd0) begin
               if (!ticks[31] && ticks != 32'd0 && nd != 64'd0 && !nd[63]) begin
                  ticks_in = ticks[30:0];
                  nd_in    = nd;
                  state_in = ST_SRDIV;
               end
            end
         end
         ST_SRDIV: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.num      = {1'b0, ticks_ff, 32'd0} - {33'd0, ticks_ff};
            div_req.divisor  = nd_ff;
            div_req.steps    = 7'd64;
            state_in         = ST_SRWAIT;
         end
         ST_SRWAIT: begin
            if (div_rsp.done) begin
               clock_rate_in = (div_rsp.quot[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                              : div_rsp.quot[31:0];
               state_in      = ST_IDLE;
            end
         end

         // Report: flags and interval counts first.
         ST_REQ0: begin
            rv_in        = sender_seen_ff;
            active_in    = inactive_ff < inactive_limit;
            validated_in = items_ff >= {24'd0, inactive_limit};
            delete_in    = (items_ff < {24'd0, inactive_limit} &&
                            !(inactive_ff < inactive_limit)) ||
                           (items_ff >= {24'd0, inactive_limit} &&
                            !(inactive_ff < inactive_limit) &&
                            cur_ff.event_time > inact_start_ff &&
                            idle_gap > delete_timeout);
            expected_in  = {2'd0, ext} - {18'd0, seq_base_ff} + 34'd1;
            exp_i_in     = ext - prior_ext_ff;
            rec_i_in     = pkts_ff - pkts_prior_ff;
            dlsr_in      = 32'd0;
            if (sr_seen_ff && cur_ff.event_time >= sr_arrival_ff) begin
               dlsr_in = (sr_gap[47:32] != 16'd0) ? 32'hFFFF_FFFF : sr_gap[31:0];
            end
            state_in = sender_seen_ff ? ST_REQ1 : ST_OUT;
         end

         // Cumulative loss and the fraction, dividing only when below one.
         ST_REQ1: begin
            if (lost35 > 35'sd2147483647) begin
               lost_in = 32'h7FFF_FFFF;
            end else if (lost35 < -35'sd2147483648) begin
               lost_in = 32'h8000_0000;
            end else begin
               lost_in = lost35[31:0];
            end
            frac_in  = 8'd0;
            state_in = ST_OUT;
            if (lost_i > 33'sd0 && $signed(exp_i_ff) > 32'sd0) begin
               if (lost_i >= $signed({exp_i_ff[31], exp_i_ff})) begin
                  frac_in = 8'hFF;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.rem_init = {31'd0, lost_i};
                  div_req.num      = '0;
                  div_req.divisor  = {32'd0, exp_i_ff};
                  div_req.steps    = 7'd8;
                  state_in         = ST_REQWAIT;
               end
            end
         end
         ST_REQWAIT: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quot[7:0];
               state_in = ST_OUT;
            end
         end

         // Load the output register once it is free.
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in                     = 1'b1;
               rsp_data_in                      = '0;
               rsp_data_in.report_valid         = rv_ff;
               rsp_data_in.is_active            = active_ff;
               rsp_data_in.is_validated         = validated_ff;
               rsp_data_in.to_delete            = delete_ff;
               if (rv_ff) begin
                  rsp_data_in.fraction_lost        = frac_ff;
                  rsp_data_in.cumulative_lost      = lost_ff;
                  rsp_data_in.extended_highest_seq = ext;
                  rsp_data_in.jitter_out           = jitter_ff[35:4];
                  rsp_data_in.last_sr              = last_sr_mid_ff;
                  rsp_data_in.delay_since_sr       = dlsr_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         seq_base_ff     <= '0;
         highest_ff      <= '0;
         wrap_ff         <= '0;
         prior_ext_ff    <= '0;
         pkts_ff         <= '0;
         pkts_prior_ff   <= '0;
         jitter_ff       <= '0;
         clock_rate_ff   <= '0;
         sr_rtp_ff       <= '0;
         sr_ntp_ff       <= '0;
         last_stamp_ff   <= '0;
         last_arrival_ff <= '0;
         sr_arrival_ff   <= '0;
         inactive_ff     <= '0;
         inact_start_ff  <= '0;
         items_ff        <= '0;
         sender_seen_ff  <= 1'b0;
         sr_seen_ff      <= 1'b0;
         last_sr_mid_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         seq_base_ff     <= seq_base_in;
         highest_ff      <= highest_in;
         wrap_ff         <= wrap_in;
         prior_ext_ff    <= prior_ext_in;
         pkts_ff         <= pkts_in;
         pkts_prior_ff   <= pkts_prior_in;
         jitter_ff       <= jitter_in;
         clock_rate_ff   <= clock_rate_in;
         sr_rtp_ff       <= sr_rtp_in;
         sr_ntp_ff       <= sr_ntp_in;
         last_stamp_ff   <= last_stamp_in;
         last_arrival_ff <= last_arrival_in;
         sr_arrival_ff   <= sr_arrival_in;
         inactive_ff     <= inactive_in;
         inact_start_ff  <= inact_start_in;
         items_ff        <= items_in;
         sender_seen_ff  <= sender_seen_in;
         sr_seen_ff      <= sr_seen_in;
         last_sr_mid_ff  <= last_sr_mid_in;
      end
      cur_ff       <= cur_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      tsd_ff       <= tsd_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      rc_ff        <= rc_in;
      ovf_ff       <= ovf_in;
      psum_ff      <= psum_in;
      term_ff      <= term_in;
      d_ff         <= d_in;
      ad_ff        <= ad_in;
      ticks_ff     <= ticks_in;
      nd_ff        <= nd_in;
      expected_ff  <= expected_in;
      exp_i_ff     <= exp_i_in;
      rec_i_ff     <= rec_i_in;
      lost_ff      <= lost_in;
      frac_ff      <= frac_in;
      dlsr_ff      <= dlsr_in;
      rv_ff        <= rv_in;
      active_ff    <= active_in;
      validated_ff <= validated_in;
      delete_ff    <= delete_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/core/rtp_receiver_statistics_unit.sv */
// ----------------------------------------------------------------------------
// RTP receiver statistics unit
// Per-source reception statistics and receiver report fields for one source.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are carried out one at a time by the
// back-end sequencer. Description chunks and interval ticks finish in the
// idle state; every data packet but the first also runs the jitter update
// once a clock rate is known (the update runs its arrival term through one
// shared 18x32 multiplier in three passes). A report request passes the flag
// state and, once a data packet has arrived, the loss state, waits when the
// fraction lost needs its 8-step division, and may wait for the output
// register. The sender report that learns the clock rate waits on the shared
// restoring divider, which yields one quotient bit per cycle. Configuration
// writes are always ready and must be made while the block is idle.
module rtp_receiver_statistics_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rrs_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rrs_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [47:0]                       csr_wdata
);

   logic [7:0]       inactive_limit_ff, inactive_limit_in;
   logic [47:0]      delete_timeout_ff, delete_timeout_in;
   logic             q_valid;
   logic             q_pop;
   rrs_pkg::req_type q_item;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      inactive_limit_in = inactive_limit_ff;
      delete_timeout_in = delete_timeout_ff;
      if (csr_valid) begin
         case (csr_index)
            rrs_pkg::CSR_INACTIVE_LIMIT: begin
               inactive_limit_in = csr_wdata[7:0];
            end
            rrs_pkg::CSR_DELETE_TIMEOUT: begin
               delete_timeout_in = csr_wdata;
            end
            default: begin
               inactive_limit_in = inactive_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inactive_limit_ff <= rrs_pkg::INACTIVE_LIMIT_RST;
         delete_timeout_ff <= rrs_pkg::DELETE_TIMEOUT_RST;
      end else begin
         inactive_limit_ff <= inactive_limit_in;
         delete_timeout_ff <= delete_timeout_in;
      end
   end

   // Front end with the item queue.
   rrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // Back end sequencer and output register.
   rrs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .inactive_limit (inactive_limit_ff),
      .delete_timeout (delete_timeout_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

   // The back end pops only an item that is actually queued.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue popped while empty");

   // The front end stalls only when it holds items for the back end.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> q_valid)
      else $error("input stalled with nothing queued");

endmodule
